// ===== design/integer_text_parser_defines.svh =====
// Assertion macros used by the parser RTL.
`ifndef INTEGER_TEXT_PARSER_DEFINES_SVH
`define INTEGER_TEXT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define ITP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integer_text_parser: same-cycle check failed");

`define ITP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("integer_text_parser: next-cycle check failed");

`else

`define ITP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ITP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/itp_pkg.sv =====
package itp_pkg;

   localparam int POSITION_WIDTH_DEFAULT = 16;
   localparam int CHAR_WIDTH             = 8;
   localparam int VALUE_WIDTH            = 64;
   localparam int COUNT_WIDTH            = 16;
   localparam int CSR_INDEX_WIDTH        = 1;
   localparam int CSR_DATA_WIDTH         = 1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDE_MODE   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIGNED_MODE = 1'b1;

   // Character codes.
   localparam logic [CHAR_WIDTH-1:0] CHR_NUL     = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHR_TAB     = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHR_CR      = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CHR_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHR_MINUS   = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHR_UPPER_F = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CHR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHR_LOWER_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHR_LOWER_X = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] HEX_LETTER_BIAS = 8'd10;

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_ZERO     = 6'b000010,
      PH_HEXFIRST = 6'b000100,
      PH_HEX      = 6'b001000,
      PH_DEC      = 6'b010000,
      PH_DRAIN    = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [VALUE_WIDTH-1:0] acc;
      logic                   neg;
   } parse_state_type;

   typedef struct packed {
      logic                   emit;
      logic [VALUE_WIDTH-1:0] value;
      logic                   ok;
   } parse_result_type;

endpackage

// ===== design/itp_step.sv =====
module itp_step #(
   parameter int POSITION_WIDTH = itp_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic [itp_pkg::CHAR_WIDTH-1:0]  char_byte,
   input  logic                            wide_mode,
   input  logic                            signed_mode,
   input  itp_pkg::parse_state_type        state_cur,
   input  logic [POSITION_WIDTH-1:0]       pos_cur,
   output itp_pkg::parse_state_type        state_nxt,
   output logic [POSITION_WIDTH-1:0]       pos_nxt,
   output itp_pkg::parse_result_type       result,
   output logic [itp_pkg::COUNT_WIDTH-1:0] count
);

   localparam int VW = itp_pkg::VALUE_WIDTH;
   localparam int CW = itp_pkg::COUNT_WIDTH;

   logic [itp_pkg::CHAR_WIDTH-1:0] dig_off;
   logic [itp_pkg::CHAR_WIDTH-1:0] hex_off;
   logic [3:0]                     dig_val;
   logic [3:0]                     hex_val;
   logic                           is_dig;
   logic                           is_lower_hex;
   logic                           is_upper_hex;
   logic                           is_hex;
   logic                           is_ws;
   logic [VW+3:0]                  dec_sum;
   logic                           dec_ovf;
   logic                           hex_ovf;
   logic                           range_ovf;
   logic                           pos_fail;
   logic                           neg_fail;
   logic [POSITION_WIDTH-1:0]      pos_bump;
   logic [CW-1:0]                  pos_sat;
   logic                           finish;
   logic                           fin_syntax;
   logic                           fin_ok;
   logic [VW-1:0]                  acc;

   assign acc = state_cur.acc;

   assign is_dig       = (char_byte >= itp_pkg::CHR_ZERO) && (char_byte <= itp_pkg::CHR_NINE);
   assign is_lower_hex = (char_byte >= itp_pkg::CHR_LOWER_A)
                         && (char_byte <= itp_pkg::CHR_LOWER_F);
   assign is_upper_hex = (char_byte >= itp_pkg::CHR_UPPER_A)
                         && (char_byte <= itp_pkg::CHR_UPPER_F);
   assign is_hex       = is_dig || is_lower_hex || is_upper_hex;
   assign is_ws        = (char_byte == itp_pkg::CHR_SPACE)
                         || ((char_byte >= itp_pkg::CHR_TAB) && (char_byte <= itp_pkg::CHR_CR));

   assign dig_off = char_byte - itp_pkg::CHR_ZERO;
   assign dig_val = dig_off[3:0];

   always_comb begin
      if (is_dig) begin
         hex_off = char_byte - itp_pkg::CHR_ZERO;
      end else if (is_lower_hex) begin
         hex_off = char_byte - itp_pkg::CHR_LOWER_A + itp_pkg::HEX_LETTER_BIAS;
      end else begin
         hex_off = char_byte - itp_pkg::CHR_UPPER_A + itp_pkg::HEX_LETTER_BIAS;
      end
   end
   assign hex_val = hex_off[3:0];

   // acc * 10 + digit as two shifts and two adds; any bit above the range is an overflow.
   assign dec_sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{VW{1'b0}}, dig_val};
   assign dec_ovf = wide_mode ? (|dec_sum[VW+3:VW]) : (|dec_sum[VW+3:32]);
   assign hex_ovf = wide_mode ? (|acc[VW-1:VW-4]) : (|acc[VW-1:28]);

   // Final range checks on the magnitude.
   assign range_ovf = !wide_mode && (|acc[VW-1:32]);
   assign pos_fail  = wide_mode ? acc[VW-1] : (|acc[VW-1:31]);
   assign neg_fail  = wide_mode ? (acc[VW-1] && (|acc[VW-2:0]))
                                : ((|acc[VW-1:32]) || (acc[31] && (|acc[30:0])));

   assign pos_bump = (&pos_cur) ? pos_cur : (pos_cur + 1'b1);

   generate
      if (POSITION_WIDTH > CW) begin : g_sat
         assign pos_sat = (|pos_cur[POSITION_WIDTH-1:CW]) ? {CW{1'b1}} : pos_cur[CW-1:0];
      end else begin : g_ext
         assign pos_sat = CW'(pos_cur);
      end
   endgenerate

   always_comb begin
      state_nxt  = state_cur;
      pos_nxt    = pos_cur;
      finish     = 1'b0;
      fin_syntax = 1'b0;

      unique case (state_cur.phase) inside
         itp_pkg::PH_IDLE: begin
            if ((char_byte != itp_pkg::CHR_NUL) && is_ws) begin
               pos_nxt = pos_bump;
            end else if (char_byte == itp_pkg::CHR_ZERO) begin
               pos_nxt         = pos_bump;
               state_nxt.phase = itp_pkg::PH_ZERO;
            end else if (is_dig) begin
               state_nxt.acc   = {{(VW-4){1'b0}}, dig_val};
               pos_nxt         = pos_bump;
               state_nxt.phase = itp_pkg::PH_DEC;
            end else if ((char_byte == itp_pkg::CHR_MINUS) && signed_mode) begin
               state_nxt.neg   = 1'b1;
               pos_nxt         = pos_bump;
               state_nxt.phase = itp_pkg::PH_DEC;
            end else begin
               finish = 1'b1;
            end
         end
         itp_pkg::PH_ZERO: begin
            if (char_byte == itp_pkg::CHR_LOWER_X) begin
               pos_nxt         = pos_bump;
               state_nxt.phase = itp_pkg::PH_HEXFIRST;
            end else if (is_dig) begin
               state_nxt.acc   = {{(VW-4){1'b0}}, dig_val};
               pos_nxt         = pos_bump;
               state_nxt.phase = itp_pkg::PH_DEC;
            end else begin
               finish     = 1'b1;
               fin_syntax = 1'b1;
            end
         end
         itp_pkg::PH_HEXFIRST, itp_pkg::PH_HEX: begin
            if (!is_hex) begin
               // "0x" with no digit after it is a syntax error.
               finish     = 1'b1;
               fin_syntax = (state_cur.phase == itp_pkg::PH_HEX);
            end else if (hex_ovf) begin
               finish = 1'b1;
            end else begin
               state_nxt.acc   = {acc[VW-5:0], hex_val};
               pos_nxt         = pos_bump;
               state_nxt.phase = itp_pkg::PH_HEX;
            end
         end
         itp_pkg::PH_DEC: begin
            if (!is_dig) begin
               finish     = 1'b1;
               fin_syntax = 1'b1;
            end else if (dec_ovf) begin
               finish = 1'b1;
            end else begin
               state_nxt.acc = dec_sum[VW-1:0];
               pos_nxt       = pos_bump;
            end
         end
         default: begin
            if (char_byte == itp_pkg::CHR_NUL) begin
               state_nxt.phase = itp_pkg::PH_IDLE;
               state_nxt.acc   = '0;
               state_nxt.neg   = 1'b0;
               pos_nxt         = '0;
            end else begin
               state_nxt.phase = itp_pkg::PH_DRAIN;
            end
         end
      endcase

      fin_ok = fin_syntax && !range_ovf;
      if (signed_mode) begin
         fin_ok = fin_ok && !(state_cur.neg ? neg_fail : pos_fail);
      end

      result.emit  = finish;
      result.ok    = fin_ok;
      result.value = '0;
      if (fin_ok) begin
         result.value = (signed_mode && state_cur.neg) ? ({VW{1'b0}} - acc) : acc;
      end
      count = fin_ok ? pos_sat : '0;

      if (finish) begin
         state_nxt.acc   = '0;
         state_nxt.neg   = 1'b0;
         pos_nxt         = '0;
         state_nxt.phase = (char_byte == itp_pkg::CHR_NUL) ? itp_pkg::PH_IDLE
                                                           : itp_pkg::PH_DRAIN;
      end
   end

endmodule

// ===== design/integer_text_parser.sv =====
// Streaming integer parser: one text character per item on the req_ channel.
// Leading whitespace is skipped, "0x" starts a hex number, anything else a
// decimal one (with an optional '-' in signed mode). The character that ends
// the number yields one item on the rsp_ channel with the value, an ok flag
// and the count of characters before it; after that, characters are dropped
// up to and including the next NUL.
// The csr_ channel writes wide_mode (index 0) and signed_mode (index 1); it is
// always ready and should only be used while no text is in flight.
// Throughput: one character per cycle unless a result is stalled. A taken
// character sits in the input register and is folded into the parse state
// while it is held there; its result is registered in the output register.
// The state update (shift-add on the 64-bit accumulator) sets the rate.
// When the receiver stalls, a pending result holds in the output register; the
// character that would produce the next result waits in the input register
// and req_stall rises, so no item is lost. Characters that make no result
// still wait in order behind a stalled result.
// Synchronous reset returns the parser to idle with an empty accumulator,
// empties both registers and sets wide_mode and signed_mode to 1.
`include "integer_text_parser_defines.svh"

module integer_text_parser #(
   parameter int POSITION_WIDTH = itp_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [itp_pkg::CHAR_WIDTH-1:0]      req_char_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [itp_pkg::VALUE_WIDTH-1:0]     rsp_value_bits,
   output logic                                rsp_parse_ok,
   output logic [itp_pkg::COUNT_WIDTH-1:0]     rsp_chars_consumed,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [itp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [itp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                             wide_ff, wide_in;
   logic                             signed_ff, signed_in;
   logic                             in_valid_ff, in_valid_in;
   logic [itp_pkg::CHAR_WIDTH-1:0]   char_ff;
   itp_pkg::parse_state_type         state_ff, state_in;
   logic [POSITION_WIDTH-1:0]        pos_ff, pos_in;
   logic                             out_valid_ff, out_valid_in;
   logic [itp_pkg::VALUE_WIDTH-1:0]  value_ff;
   logic                             ok_ff;
   logic [itp_pkg::COUNT_WIDTH-1:0]  count_ff;
   itp_pkg::parse_result_type        step_result;
   logic [itp_pkg::COUNT_WIDTH-1:0]  step_count;
   logic                             fire;
   logic                             req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      wide_in   = wide_ff;
      signed_in = signed_ff;
      if (csr_valid) begin
         unique case (csr_index)
            itp_pkg::CSR_WIDE_MODE:   wide_in   = csr_wdata[0];
            itp_pkg::CSR_SIGNED_MODE: signed_in = csr_wdata[0];
            default: begin
               wide_in   = wide_ff;
               signed_in = signed_ff;
            end
         endcase
      end
   end

   // The held character is processed once the output register can take a result.
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   itp_step #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_step (
      .char_byte   (char_ff),
      .wide_mode   (wide_ff),
      .signed_mode (signed_ff),
      .state_cur   (state_ff),
      .pos_cur     (pos_ff),
      .state_nxt   (state_in),
      .pos_nxt     (pos_in),
      .result      (step_result),
      .count       (step_count)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire && step_result.emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff        <= 1'b1;
         signed_ff      <= 1'b1;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.phase <= itp_pkg::PH_IDLE;
         state_ff.acc   <= '0;
         state_ff.neg   <= 1'b0;
         pos_ff         <= '0;
      end else begin
         wide_ff      <= wide_in;
         signed_ff    <= signed_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
            pos_ff   <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff <= req_char_byte;
      end
      if (fire && step_result.emit) begin
         value_ff <= step_result.value;
         ok_ff    <= step_result.ok;
         count_ff <= step_count;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_value_bits     = value_ff;
   assign rsp_parse_ok       = ok_ff;
   assign rsp_chars_consumed = count_ff;

   `ITP_ASSERT_IMPLY(a_fail_is_zero, clock, reset, out_valid_ff && !ok_ff,
                     (value_ff == '0) && (count_ff == '0))
   `ITP_ASSERT_NEXT(a_drain_after_result, clock, reset,
                    fire && step_result.emit && (char_ff != itp_pkg::CHR_NUL),
                    state_ff.phase == itp_pkg::PH_DRAIN)
   `ITP_ASSERT_NEXT(a_held_char_stays, clock, reset, in_valid_ff && !fire,
                    in_valid_ff && $stable(char_ff))
   `ITP_ASSERT_IMPLY(a_idle_is_positive, clock, reset, state_ff.phase == itp_pkg::PH_IDLE,
                     !state_ff.neg && (state_ff.acc == '0))

endmodule

// ===== dv/tb_integer_text_parser.sv =====
`timescale 1ns / 100ps

module tb_integer_text_parser;

   typedef struct packed {
      logic [itp_pkg::VALUE_WIDTH-1:0] value;
      logic                            ok;
      logic [itp_pkg::COUNT_WIDTH-1:0] count;
   } parse_out_type;

   typedef struct packed {
      logic          wide;
      logic          sgn;
      logic          nul;
      logic          typed;
      parse_out_type want;
   } dir_row_type;

   localparam parse_out_type NO_NUMBER = '{64'd0, 1'b0, 16'd0};
   localparam logic [itp_pkg::CHAR_WIDTH-1:0] CHR_UPPER_X = 8'h58;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIMIT_VALUES [7] = '{
      64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF,
      64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      ALL_ONES
   };
   localparam int DIR_ROWS = 26;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [itp_pkg::CHAR_WIDTH-1:0]      req_char_byte = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [itp_pkg::VALUE_WIDTH-1:0]     rsp_value_bits;
   logic                                rsp_parse_ok;
   logic [itp_pkg::COUNT_WIDTH-1:0]     rsp_chars_consumed;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [itp_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [itp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   integer_text_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_byte      (req_char_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value_bits     (rsp_value_bits),
      .rsp_parse_ok       (rsp_parse_ok),
      .rsp_chars_consumed (rsp_chars_consumed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Parser state mirrored in the testbench.
   itp_pkg::phase_type parse_phase = itp_pkg::PH_IDLE;
   logic [63:0]        accum = '0;
   logic               negative = 1'b0;
   logic [15:0]        position = '0;
   logic               cfg_wide = 1'b1;
   logic               cfg_signed = 1'b1;

   parse_out_type    pending_numbers [$];
   logic [7:0]       text_buf [$];
   int               mismatch_count = 0;
   int               items_sent = 0;
   int               send_idle_pct = 0;
   int               rcv_stall_pct = 0;

   string dir_text [DIR_ROWS] = '{
      "0",
      "",
      " \t\n\013\014\015-9223372036854775808 ",
      "9223372036854775807x",
      "9223372036854775808",
      "-9223372036854775809",
      "-",
      "0xg",
      "0x8000000000000000",
      "7\377\200abc",
      "18446744073709551615",
      "18446744073709551616",
      "0xFFFFffffFFFFffff",
      "0x10000000000000000",
      "-5",
      "0x",
      "4294967296",
      "",
      "4294967295",
      "4294967296",
      "0xABCDEF012",
      "0123",
      "-2147483648",
      "2147483647",
      "2147483648",
      "00x5"
   };

   // wide, signed, append NUL, expected result typed in, expected result
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{1'b1, 1'b1, 1'b1, 1'b1, '{64'd0, 1'b1, 16'd1}},
      '{1'b1, 1'b1, 1'b1, 1'b1, NO_NUMBER},
      '{1'b1, 1'b1, 1'b1, 1'b1, '{64'h8000_0000_0000_0000, 1'b1, 16'd26}},
      '{1'b1, 1'b1, 1'b1, 1'b1, '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 16'd19}},
      '{1'b1, 1'b1, 1'b1, 1'b1, NO_NUMBER},
      '{1'b1, 1'b1, 1'b1, 1'b1, NO_NUMBER},
      '{1'b1, 1'b1, 1'b1, 1'b1, '{64'd0, 1'b1, 16'd1}},
      '{1'b1, 1'b1, 1'b1, 1'b1, NO_NUMBER},
      '{1'b1, 1'b1, 1'b1, 1'b1, NO_NUMBER},
      '{1'b1, 1'b1, 1'b1, 1'b0, NO_NUMBER},
      '{1'b1, 1'b0, 1'b1, 1'b1, '{ALL_ONES, 1'b1, 16'd20}},
      '{1'b1, 1'b0, 1'b1, 1'b1, NO_NUMBER},
      '{1'b1, 1'b0, 1'b1, 1'b1, '{ALL_ONES, 1'b1, 16'd18}},
      '{1'b1, 1'b0, 1'b1, 1'b1, NO_NUMBER},
      '{1'b1, 1'b0, 1'b1, 1'b1, NO_NUMBER},
      '{1'b1, 1'b0, 1'b1, 1'b1, NO_NUMBER},
      '{1'b1, 1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{1'b0, 1'b0, 1'b1, 1'b1, NO_NUMBER},
      '{1'b0, 1'b0, 1'b1, 1'b1, '{64'h0000_0000_FFFF_FFFF, 1'b1, 16'd10}},
      '{1'b0, 1'b0, 1'b1, 1'b1, NO_NUMBER},
      '{1'b0, 1'b0, 1'b1, 1'b0, NO_NUMBER},
      '{1'b0, 1'b0, 1'b1, 1'b0, NO_NUMBER},
      '{1'b0, 1'b1, 1'b1, 1'b1, '{64'hFFFF_FFFF_8000_0000, 1'b1, 16'd11}},
      '{1'b0, 1'b1, 1'b1, 1'b1, '{64'h0000_0000_7FFF_FFFF, 1'b1, 16'd10}},
      '{1'b0, 1'b1, 1'b1, 1'b1, NO_NUMBER},
      '{1'b0, 1'b1, 1'b1, 1'b0, NO_NUMBER}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(8_000_000);
      $display("integer_text_parser test failed");
      $finish;
   end

   function automatic void clear_work();
      accum = '0;
      negative = 1'b0;
      position = '0;
   endfunction

   function automatic void bump_position();
      if (position != '1) position = position + 1'b1;
   endfunction

   // Ends the current number: range check against the live settings, then
   // back to idle on NUL or into the drain state otherwise.
   function automatic parse_out_type close_number(input logic syntax_ok, input logic [7:0] c);
      parse_out_type res;
      logic [63:0]   half;
      logic [63:0]   lim;
      logic          ok;
      res = NO_NUMBER;
      ok = syntax_ok;
      lim = cfg_wide ? ALL_ONES : 64'h0000_0000_FFFF_FFFF;
      half = cfg_wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
      if (ok && accum > lim) ok = 1'b0;
      else if (ok && cfg_signed) begin
         if (negative ? (accum > half) : (accum > half - 1)) ok = 1'b0;
      end
      if (ok) begin
         res.value = (cfg_signed && negative) ? -accum : accum;
         res.ok = 1'b1;
         res.count = position;
      end
      clear_work();
      parse_phase = (c == itp_pkg::CHR_NUL) ? itp_pkg::PH_IDLE : itp_pkg::PH_DRAIN;
      return res;
   endfunction

   // Advances the mirrored parser by one character; returns 1 when the
   // character ends a number, with the expected result in res.
   function automatic logic parse_char(input logic [7:0] c, output parse_out_type res);
      logic        is_dig;
      logic        is_hex;
      logic [3:0]  nib;
      logic [63:0] lim;
      res = NO_NUMBER;
      lim = cfg_wide ? ALL_ONES : 64'h0000_0000_FFFF_FFFF;
      is_dig = (c >= itp_pkg::CHR_ZERO) && (c <= itp_pkg::CHR_NINE);
      is_hex = 1'b1;
      nib = 4'(c - itp_pkg::CHR_ZERO);
      if (c >= itp_pkg::CHR_LOWER_A && c <= itp_pkg::CHR_LOWER_F)
         nib = 4'(c - itp_pkg::CHR_LOWER_A + itp_pkg::HEX_LETTER_BIAS);
      else if (c >= itp_pkg::CHR_UPPER_A && c <= itp_pkg::CHR_UPPER_F)
         nib = 4'(c - itp_pkg::CHR_UPPER_A + itp_pkg::HEX_LETTER_BIAS);
      else is_hex = is_dig;
      case (parse_phase) inside
         itp_pkg::PH_IDLE: begin
            if (c == itp_pkg::CHR_SPACE || (c >= itp_pkg::CHR_TAB && c <= itp_pkg::CHR_CR))
               bump_position();
            else if (c == itp_pkg::CHR_ZERO) begin
               bump_position();
               parse_phase = itp_pkg::PH_ZERO;
            end else if (is_dig) begin
               accum = {60'd0, nib};
               bump_position();
               parse_phase = itp_pkg::PH_DEC;
            end else if (c == itp_pkg::CHR_MINUS && cfg_signed) begin
               negative = 1'b1;
               bump_position();
               parse_phase = itp_pkg::PH_DEC;
            end else begin
               res = close_number(1'b0, c);
               return 1'b1;
            end
         end
         itp_pkg::PH_ZERO: begin
            if (c == itp_pkg::CHR_LOWER_X) begin
               bump_position();
               parse_phase = itp_pkg::PH_HEXFIRST;
            end else if (is_dig) begin
               accum = {60'd0, nib};
               bump_position();
               parse_phase = itp_pkg::PH_DEC;
            end else begin
               res = close_number(1'b1, c);
               return 1'b1;
            end
         end
         itp_pkg::PH_HEXFIRST, itp_pkg::PH_HEX: begin
            if (!is_hex) begin
               res = close_number(parse_phase == itp_pkg::PH_HEX, c);
               return 1'b1;
            end else if (accum > (lim >> 4)) begin
               res = close_number(1'b0, c);
               return 1'b1;
            end
            accum = {accum[59:0], nib};
            bump_position();
            parse_phase = itp_pkg::PH_HEX;
         end
         itp_pkg::PH_DEC: begin
            if (!is_dig) begin
               res = close_number(1'b1, c);
               return 1'b1;
            end else if (accum > lim || accum > (lim - nib) / 10) begin
               res = close_number(1'b0, c);
               return 1'b1;
            end
            accum = accum * 10 + nib;
            bump_position();
         end
         default: begin
            if (c == itp_pkg::CHR_NUL) begin
               clear_work();
               parse_phase = itp_pkg::PH_IDLE;
            end
         end
      endcase
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: MISMATCH: %s", $time, what);
      mismatch_count++;
   endtask

   // Typed-in expectations replace the predicted ones for their row.
   task automatic send_char(input logic [7:0] c, input logic typed,
                            input parse_out_type typed_res);
      parse_out_type res;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_byte <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (parse_char(c, res)) pending_numbers.push_back(typed ? typed_res : res);
      items_sent++;
   endtask

   task automatic send_text(input logic typed, input parse_out_type typed_res);
      foreach (text_buf[i]) send_char(text_buf[i], typed, typed_res);
   endtask

   // Holds the sender until every result is back and the pipeline is empty.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_numbers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input logic wide, input logic sgn);
      csr_valid <= 1'b1;
      csr_index <= itp_pkg::CSR_WIDE_MODE;
      csr_wdata <= wide;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_wide = wide;
      csr_index <= itp_pkg::CSR_SIGNED_MODE;
      csr_wdata <= sgn;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_signed = sgn;
      csr_valid <= 1'b0;
   endtask

   function automatic void build_random_text();
      logic [63:0] num;
      logic [7:0]  ch;
      string       digits;
      int          pick;
      text_buf.delete();
      if ($urandom_range(99) < 10) begin
         // Noise: random bytes that rarely form a number.
         repeat ($urandom_range(1, 6)) begin
            ch = 8'($urandom_range(255));
            text_buf.push_back(ch);
         end
         text_buf.push_back(itp_pkg::CHR_NUL);
         return;
      end
      repeat ($urandom_range(3)) begin
         ch = 8'($urandom_range(itp_pkg::CHR_TAB, itp_pkg::CHR_CR + 1));
         text_buf.push_back(ch > itp_pkg::CHR_CR ? itp_pkg::CHR_SPACE : ch);
      end
      if ($urandom_range(3) == 0) text_buf.push_back(itp_pkg::CHR_MINUS);
      pick = $urandom_range(99);
      if (pick < 40) num = 64'($urandom_range(99999));
      else if (pick < 60) num = {$urandom(), $urandom()} >> $urandom_range(63);
      else num = LIMIT_VALUES[$urandom_range(6)] + 64'($urandom_range(4)) - 64'd2;
      if ($urandom_range(2) == 0) begin
         digits = $sformatf("%0h", num);
         text_buf.push_back(itp_pkg::CHR_ZERO);
         text_buf.push_back($urandom_range(9) == 0 ? CHR_UPPER_X : itp_pkg::CHR_LOWER_X);
         if ($urandom_range(19) == 0) digits = "";
      end else begin
         digits = $sformatf("%0d", num);
      end
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 2)) text_buf.push_back(itp_pkg::CHR_ZERO);
      end
      for (int i = 0; i < digits.len(); i++) begin
         ch = digits[i];
         if (ch >= itp_pkg::CHR_LOWER_A && ch <= itp_pkg::CHR_LOWER_F
             && $urandom_range(1) == 1)
            ch = ch - itp_pkg::CHR_LOWER_A + itp_pkg::CHR_UPPER_A;
         text_buf.push_back(ch);
      end
      // An extra digit pushes boundary values past 64 bits.
      if ($urandom_range(7) == 0) begin
         ch = itp_pkg::CHR_ZERO + 8'($urandom_range(9));
         text_buf.push_back(ch);
      end
      if ($urandom_range(1) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            ch = 8'($urandom_range(1, 255));
            text_buf.push_back(ch);
         end
      end
      text_buf.push_back(itp_pkg::CHR_NUL);
   endfunction

   always @(posedge clock) begin
      parse_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_numbers.size() == 0) begin
            report_mismatch($sformatf("unexpected result, value_bits %h", rsp_value_bits));
         end else begin
            want = pending_numbers.pop_front();
            if (rsp_value_bits !== want.value)
               report_mismatch($sformatf("value_bits %h, expected %h",
                                         rsp_value_bits, want.value));
            if (rsp_parse_ok !== want.ok)
               report_mismatch($sformatf("parse_ok %b, expected %b", rsp_parse_ok, want.ok));
            if (rsp_chars_consumed !== want.count)
               report_mismatch($sformatf("chars_consumed %0d, expected %0d",
                                         rsp_chars_consumed, want.count));
         end
      end
      rsp_stall <= (rcv_stall_pct != 0) && ($urandom_range(99) < rcv_stall_pct);
   end

   initial begin
      int         cfg;
      int         seg_target;
      logic [7:0] ch;
      send_idle_pct = 6;
      rcv_stall_pct = 80;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].wide != cfg_wide || dir_rows[r].sgn != cfg_signed) begin
            wait_drained();
            write_config(dir_rows[r].wide, dir_rows[r].sgn);
         end
         text_buf.delete();
         for (int i = 0; i < dir_text[r].len(); i++) begin
            ch = dir_text[r][i];
            text_buf.push_back(ch);
         end
         if (dir_rows[r].nul) text_buf.push_back(itp_pkg::CHR_NUL);
         send_text(dir_rows[r].typed, dir_rows[r].want);
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 80 : 0;
         rcv_stall_pct = (ph == 0) ? 80 : (ph == 1) ? 6 : 0;
         for (int seg = 0; seg < 4; seg++) begin
            wait_drained();
            cfg = (ph == 0) ? seg : $urandom_range(3);
            write_config(cfg[1], cfg[0]);
            seg_target = items_sent + 80;
            while (items_sent < seg_target) begin
               build_random_text();
               send_text(1'b0, NO_NUMBER);
            end
         end
      end

      req_valid <= 1'b0;
      for (int k = 0; k < 5000 && pending_numbers.size() != 0; k++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (pending_numbers.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_numbers.size()));
      if (mismatch_count == 0) begin
         $display("integer_text_parser test passed");
      end else begin
         $display("integer_text_parser test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/itp_pkg.sv
design/itp_step.sv
design/integer_text_parser.sv
dv/tb_integer_text_parser.sv
